[design/sse_pkg.sv]
// ----------------------------------------------------------------------------
// Shell sort engine package
// Shared types and constants for the shell sort engine core and its sort
// sequencer.
// ----------------------------------------------------------------------------
package sse_pkg;

    // Width of one stored element.
    localparam int DATA_W = 32;

    // Top level control states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_OUT_RD,
        ST_OUT_WAIT
    } t_top_state;

    // Sort sequencer states.
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_CHECK,
        SQ_PICK,
        SQ_PICK_WAIT,
        SQ_CMP,
        SQ_PLACE
    } t_seq_state;

    // Status reported by the sort sequencer to the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_stat;

endpackage

[design/sse_sort_seq.sv]
// ----------------------------------------------------------------------------
// Shell sort sequencer
// Walks the element store with a halving gap and performs a gapped insertion
// per pass, one memory read and at most one memory write per cycle.
// ----------------------------------------------------------------------------
module sse_sort_seq
    import sse_pkg::*;
#(
    parameter int MAX_ELEMS = 64,
    localparam int AW = $clog2(MAX_ELEMS),
    localparam int CW = $clog2(MAX_ELEMS + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [CW-1:0]            i_count,
    input  logic signed [DATA_W-1:0] i_rdata,
    output logic [AW-1:0]            o_raddr,
    output logic                     o_we,
    output logic [AW-1:0]            o_waddr,
    output logic signed [DATA_W-1:0] o_wdata,
    output t_seq_stat                o_stat
);

    t_seq_state               r_state, n_state;
    logic [CW-1:0]            r_n, n_n;
    logic [CW-1:0]            r_gap, n_gap;
    logic [CW-1:0]            r_i, n_i;
    logic [CW-1:0]            r_pos, n_pos;
    logic signed [DATA_W-1:0] r_picked, n_picked;

    logic [CW-1:0] idx_less_gap;
    logic [CW-1:0] pos_less_gap;
    logic [CW-1:0] pos_less_2gap;

    // Neighbor positions one gap below the current index and position, and two gaps below the position.
    assign idx_less_gap  = r_i - r_gap;
    assign pos_less_gap  = r_pos - r_gap;
    assign pos_less_2gap = pos_less_gap - r_gap;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pass and insertion registers; only meaningful while a sort runs.
    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_gap    <= n_gap;
        r_i      <= n_i;
        r_pos    <= n_pos;
        r_picked <= n_picked;
    end

    // Next state and memory accesses.
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_gap       = r_gap;
        n_i         = r_i;
        n_pos       = r_pos;
        n_picked    = r_picked;
        o_raddr     = r_i[AW-1:0];
        o_we        = 1'b0;
        o_waddr     = r_pos[AW-1:0];
        o_wdata     = r_picked;
        o_stat.done = 1'b0;
        o_stat.busy = (r_state != SQ_IDLE);

        case (r_state)
            SQ_IDLE: begin
                if (i_start) begin
                    n_n     = i_count;
                    n_gap   = i_count >> 1;
                    n_i     = i_count >> 1;
                    n_state = SQ_CHECK;
                end
            end
            SQ_CHECK: begin
                // End of a pass halves the gap; a zero gap ends the sort.
                if (r_gap == '0) begin
                    o_stat.done = 1'b1;
                    n_state     = SQ_IDLE;
                end else if (r_i >= r_n) begin
                    n_gap = r_gap >> 1;
                    n_i   = r_gap >> 1;
                end else begin
                    n_state = SQ_PICK;
                end
            end
            SQ_PICK: begin
                o_raddr = r_i[AW-1:0];
                n_state = SQ_PICK_WAIT;
            end
            SQ_PICK_WAIT: begin
                n_picked = i_rdata;
                n_pos    = r_i;
                o_raddr  = idx_less_gap[AW-1:0];
                n_state  = SQ_CMP;
            end
            SQ_CMP: begin
                // A greater neighbor moves up one gap; otherwise the picked
                // element settles in the current position.
                o_we = 1'b1;
                if (i_rdata > r_picked) begin
                    o_wdata = i_rdata;
                    n_pos   = pos_less_gap;
                    if (pos_less_gap >= r_gap) begin
                        o_raddr = pos_less_2gap[AW-1:0];
                    end else begin
                        n_state = SQ_PLACE;
                    end
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = SQ_CHECK;
                end
            end
            SQ_PLACE: begin
                o_we    = 1'b1;
                n_i     = r_i + CW'(1);
                n_state = SQ_CHECK;
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    // The compare position always has a neighbor one gap below it.
    a_cmp_has_neighbor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_CMP) |-> (r_pos >= r_gap) && (r_pos < r_n))
        else $error("compare position without a lower neighbor");

    // Every store write stays inside the batch.
    a_write_in_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> ({1'b0, o_waddr} < {1'b0, r_n}))
        else $error("sort write beyond the element count");

    // Every pick runs with a nonzero gap no larger than half the batch.
    a_gap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_PICK) |-> (r_gap != '0) && (r_gap <= (r_n >> 1)))
        else $error("gap out of range");

endmodule

[design/shell_sort_engine_core.sv]
// ----------------------------------------------------------------------------
// Shell sort engine core
// Collects signed elements into an on-chip store, sorts them by Shell sort on
// the final item and streams them out in ascending order.
// ----------------------------------------------------------------------------
// Sequence: items are taken while ready is high; after the final item the
//   sort runs each insertion through check, pick, pick wait and a compare
//   per neighbor examined, plus a place step at the bottom, and halves the
//   gap at each pass end; results then leave one at a time, each read
//   starting once the previous result is taken. Ready is low from the
//   final item until the last result is in the output register.
// Reset: clears the state machines, element count, overflow flag and output
//   valid; the store contents are not cleared.
module shell_sort_engine_core
    import sse_pkg::*;
#(
    parameter int MAX_ELEMS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_final_item,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_final_result,
    output logic                     o_dropped
);

    localparam int AW = $clog2(MAX_ELEMS);
    localparam int CW = $clog2(MAX_ELEMS + 1);

    t_top_state               r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_ovf, n_ovf;
    logic [AW-1:0]            r_k, n_k;
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_value, n_out_value;
    logic                     r_out_final, n_out_final;
    logic                     r_out_dropped, n_out_dropped;

    logic signed [DATA_W-1:0] r_mem [MAX_ELEMS];
    logic signed [DATA_W-1:0] r_rdata;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;

    logic                     in_xfer;
    logic                     out_xfer;
    logic                     has_room;
    logic                     k_last;
    logic                     seq_start;
    logic [AW-1:0]            seq_raddr;
    logic                     seq_we;
    logic [AW-1:0]            seq_waddr;
    logic signed [DATA_W-1:0] seq_wdata;
    t_seq_stat                seq_stat;

    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = r_out_valid && i_ready;
    assign has_room = (r_count < CW'(MAX_ELEMS));
    assign k_last   = ((CW'(r_k) + CW'(1)) == r_count);

    assign o_ready        = (r_state == ST_LOAD);
    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_final_result = r_out_final;
    assign o_dropped      = r_out_dropped;

    // Sort sequencer.
    sse_sort_seq #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (seq_start),
        .i_count (n_count),
        .i_rdata (r_rdata),
        .o_raddr (seq_raddr),
        .o_we    (seq_we),
        .o_waddr (seq_waddr),
        .o_wdata (seq_wdata),
        .o_stat  (seq_stat)
    );

    // Element store: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Readout index and output payload.
    always_ff @(posedge i_clk) begin
        r_k           <= n_k;
        r_out_value   <= n_out_value;
        r_out_final   <= n_out_final;
        r_out_dropped <= n_out_dropped;
    end

    // Next state, store access arbitration and output register loading.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_ovf         = r_ovf;
        n_k           = r_k;
        n_out_valid   = r_out_valid && !out_xfer;
        n_out_value   = r_out_value;
        n_out_final   = r_out_final;
        n_out_dropped = r_out_dropped;
        mem_we        = 1'b0;
        mem_waddr     = r_count[AW-1:0];
        mem_wdata     = i_value;
        mem_raddr     = r_k;
        seq_start     = 1'b0;

        case (r_state)
            ST_LOAD: begin
                // Store the element if there is room, else note the drop.
                if (in_xfer) begin
                    if (has_room) begin
                        mem_we  = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_final_item) begin
                        seq_start = 1'b1;
                        n_state   = ST_SORT;
                    end
                end
            end
            ST_SORT: begin
                mem_we    = seq_we;
                mem_waddr = seq_waddr;
                mem_wdata = seq_wdata;
                mem_raddr = seq_raddr;
                if (seq_stat.done) begin
                    n_k     = '0;
                    n_state = ST_OUT_RD;
                end
            end
            ST_OUT_RD: begin
                // Read the next element once the output register is free.
                mem_raddr = r_k;
                if (!r_out_valid) begin
                    n_state = ST_OUT_WAIT;
                end
            end
            ST_OUT_WAIT: begin
                n_out_valid   = 1'b1;
                n_out_value   = r_rdata;
                n_out_final   = k_last;
                n_out_dropped = r_ovf;
                if (k_last) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = ST_LOAD;
                end else begin
                    n_k     = r_k + AW'(1);
                    n_state = ST_OUT_RD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // The element count never passes the store capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ELEMS))
        else $error("element count beyond capacity");

    // The sequencer runs and writes the store only in the sort state.
    a_seq_in_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (seq_stat.busy || seq_we) |-> (r_state == ST_SORT))
        else $error("sequencer active outside the sort state");

    // A sort start always finds the sequencer idle.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_start |-> !seq_stat.busy)
        else $error("sort started while sequencer busy");

    // The output register is empty whenever a new result is loaded.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT_WAIT) |-> !r_out_valid)
        else $error("result loaded over a pending result");

    // Readout never runs past the batch.
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT_WAIT) |-> (CW'(r_k) < r_count))
        else $error("readout index beyond the element count");

endmodule
